// ===== hdl/hrle_pkg.sv =====
// Shared types, character codes and run-formatting functions for the hex RLE text encoder.
// No dependencies; used by every module of the block.
package hrle_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    localparam logic [6:0] CHAR_STAR  = 7'h2A;
    localparam logic [6:0] CHAR_CARET = 7'h5E;
    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h41;

    // One queued word: up to two runs to write, run A before run B.
    // Run B is present only when the symbol carried the last flag.
    typedef struct packed {
        logic       has_a;
        logic [3:0] sym_a;
        logic [7:0] len_a;
        logic       has_b;
        logic [3:0] sym_b;
        logic [7:0] len_b;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        if (d < 4'd10) begin
            hex_char = CHAR_ZERO + {3'b000, d};
        end else begin
            hex_char = CHAR_A + {3'b000, d - 4'd10};
        end
    endfunction

    // Character at position pos of the text for a run of len symbols.
    function automatic logic [6:0] run_char(input logic [7:0] len, input logic [3:0] sym,
                                            input logic [1:0] pos);
        run_char = hex_char(sym);
        if (len >= 8'd16) begin
            unique case (pos)
                2'd0: run_char = CHAR_CARET;
                2'd1: run_char = hex_char(len[7:4]);
                2'd2: run_char = hex_char(len[3:0]);
                default: run_char = hex_char(sym);
            endcase
        end else if (len > 8'd3) begin
            unique case (pos)
                2'd0: run_char = CHAR_STAR;
                2'd1: run_char = hex_char(len[3:0]);
                default: run_char = hex_char(sym);
            endcase
        end
    endfunction

    // True at the last character of the run's text.
    function automatic logic run_last(input logic [7:0] len, input logic [1:0] pos);
        if (len >= 8'd16) begin
            run_last = (pos == 2'd3);
        end else if (len > 8'd3) begin
            run_last = (pos == 2'd2);
        end else begin
            run_last = (pos == 2'(len[1:0] - 2'd1));
        end
    endfunction

endpackage

// ===== hdl/hrle_front.sv =====
// Front end: tracks the open run and turns each accepted symbol into at most one queue word.
// Depends on hrle_pkg.
module hrle_front #(
    parameter int unsigned MAX_RUN = 255
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [3:0]        in_value,
    input  logic              in_last,
    output logic              in_ready,
    input  hrle_pkg::q_status_t q_status,
    output logic              push,
    output hrle_pkg::cmd_t    push_cmd
);

    logic [3:0] run_sym_reg, run_sym_next;
    logic [7:0] run_len_reg, run_len_next;
    logic       run_open_reg, run_open_next;
    logic       accept;
    logic       grow;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign grow     = run_open_reg && (in_value == run_sym_reg)
                      && (run_len_reg < 8'(MAX_RUN));

    always_comb begin
        run_sym_next  = run_sym_reg;
        run_len_next  = run_len_reg;
        run_open_next = run_open_reg;
        push_cmd      = '0;
        push          = 1'b0;
        if (accept) begin
            if (grow) begin
                run_len_next = run_len_reg + 8'd1;
            end else begin
                // close the old run and open a fresh one
                push_cmd.has_a = run_open_reg;
                push_cmd.sym_a = run_sym_reg;
                push_cmd.len_a = run_len_reg;
                run_sym_next   = in_value;
                run_len_next   = 8'd1;
                run_open_next  = 1'b1;
            end
            if (in_last) begin
                push_cmd.has_b = 1'b1;
                push_cmd.sym_b = run_sym_next;
                push_cmd.len_b = run_len_next;
                run_sym_next   = 4'd0;
                run_len_next   = 8'd0;
                run_open_next  = 1'b0;
            end
            push = push_cmd.has_a || push_cmd.has_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_sym_reg  <= 4'd0;
            run_len_reg  <= 8'd0;
            run_open_reg <= 1'b0;
        end else begin
            run_sym_reg  <= run_sym_next;
            run_len_reg  <= run_len_next;
            run_open_reg <= run_open_next;
        end
    end

endmodule

// ===== hdl/hrle_queue.sv =====
// Small register queue of run-write words between front and back end.
// Depends on hrle_pkg.
module hrle_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hrle_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output hrle_pkg::q_status_t status,
    output hrle_pkg::cmd_t      head
);

    hrle_pkg::cmd_t mem [hrle_pkg::QDEPTH];
    logic [hrle_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [hrle_pkg::QCNT_W-1:0] count_reg;

    assign status.full  = (count_reg == hrle_pkg::QCNT_W'(hrle_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hdl/hrle_back.sv =====
// Back end: expands queued run words into one text character per cycle while out_ready allows, into an output register.
// Depends on hrle_pkg.
module hrle_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  hrle_pkg::q_status_t q_status,
    input  hrle_pkg::cmd_t      head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          out_char,
    output logic                out_item_done,
    output logic                out_text_done
);

    logic       valid_reg;
    logic [6:0] char_reg;
    logic       item_done_reg, text_done_reg;
    logic       phase_reg;
    logic [1:0] pos_reg;
    logic       advance, fire, use_b, run_end, entry_end;
    logic [7:0] cur_len;
    logic [3:0] cur_sym;

    assign advance   = !valid_reg || out_ready;
    assign fire      = advance && !q_status.empty;
    // skip run A when the word carries only the flushed run
    assign use_b     = phase_reg || !head.has_a;
    assign cur_len   = use_b ? head.len_b : head.len_a;
    assign cur_sym   = use_b ? head.sym_b : head.sym_a;
    assign run_end   = hrle_pkg::run_last(cur_len, pos_reg);
    assign entry_end = run_end && (use_b || !head.has_b);
    assign pop       = fire && entry_end;

    assign out_valid     = valid_reg;
    assign out_char      = char_reg;
    assign out_item_done = item_done_reg;
    assign out_text_done = text_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
            pos_reg   <= 2'd0;
        end else if (advance) begin
            valid_reg <= !q_status.empty;
            if (fire) begin
                if (entry_end) begin
                    phase_reg <= 1'b0;
                    pos_reg   <= 2'd0;
                end else if (run_end) begin
                    phase_reg <= 1'b1;
                    pos_reg   <= 2'd0;
                end else begin
                    pos_reg <= pos_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            char_reg      <= hrle_pkg::run_char(cur_len, cur_sym, pos_reg);
            item_done_reg <= entry_end;
            text_done_reg <= entry_end && head.has_b;
        end
    end

endmodule

// ===== hdl/hex_rle_text_encoder_unit.sv =====
// Hex run-length text encoder, top level: front end, word queue and character back end.
// Depends on hrle_pkg, hrle_front, hrle_queue and hrle_back.
//
// Accepts one 4-bit symbol per cycle and writes run-length-encoded ASCII hex text, one
// character per output word. Symbols that only extend a run produce nothing; a run end
// produces 1 to 4 characters ('^' or '*' forms for runs of 16+ or 4..15), and a symbol with
// s_tlast set flushes the open run as well, so one input word causes at most 5 characters.
// The output side emits one character per cycle while m_tready is high, from a registered
// output stage; the front end queues up to 4 run-write words, and s_tready drops only while
// that queue is full. Runs are closed at MAX_RUN symbols and a new run starts. m_tuser marks
// the last character caused by an input word, m_tlast the last character of the whole text.
module hex_rle_text_encoder_unit #(
    parameter int unsigned MAX_RUN = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [3:0] value, [7:4] zero
    input  logic       s_tlast,   // final_req
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] text_char, [7] zero
    output logic [0:0] m_tuser,   // [0] item_done
    output logic       m_tlast    // text_done
);

    hrle_pkg::q_status_t q_status;
    hrle_pkg::cmd_t      push_cmd, head;
    logic                push, pop;
    logic [6:0]          text_char;
    logic                item_done;

    hrle_front #(.MAX_RUN(MAX_RUN)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_value (s_tdata[3:0]),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    hrle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .status   (q_status),
        .head     (head)
    );

    hrle_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_status      (q_status),
        .head          (head),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_char      (text_char),
        .out_item_done (item_done),
        .out_text_done (m_tlast)
    );

    assign m_tdata = {1'b0, text_char};
    assign m_tuser = item_done;

endmodule

// ===== hdl/hrle_checker.sv =====
// Port-level checks on the encoder's output stream, bound to the top level.
// Depends on hex_rle_text_encoder_unit.
module hrle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // end of text always ends the input word's characters too
    a_text_end_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[0])
        else $error("text end without item end");

    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >= 8'h30 && m_tdata <= 8'h39)
                   || (m_tdata >= 8'h41 && m_tdata <= 8'h46)
                   || m_tdata == 8'h2A || m_tdata == 8'h5E))
        else $error("character outside encoder alphabet");

    // a marker never closes an input word's characters
    a_marker_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata == 8'h2A || m_tdata == 8'h5E)) |-> !m_tuser[0])
        else $error("marker flagged as last character");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled output word changed");

endmodule

bind hex_rle_text_encoder_unit hrle_checker u_hrle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for hex_rle_text_encoder_unit: directed table, then random runs.
// Depends on the block and its package only; expected text comes from a local run encoder.
module testbench;

    localparam int unsigned MAX_RUN = 255;
    localparam logic [6:0] ASCII_ZERO  = 7'h30;
    localparam logic [6:0] ASCII_A     = 7'h41;
    localparam logic [6:0] ASCII_STAR  = 7'h2A;
    localparam logic [6:0] ASCII_CARET = 7'h5E;
    localparam int RANDOM_ITEMS = 248;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_WORD = 6;
    localparam int DIR_ROWS = 22;

    typedef struct packed {
        logic [6:0] ch;
        logic       item_done;
        logic       text_done;
    } text_word_t;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [3:0] value, [7:4] zero
    logic       s_tlast = 1'b0;    // final_req
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [6:0] text_char, [7] zero
    logic [0:0] m_tuser;           // [0] item_done
    logic       m_tlast;           // text_done

    hex_rle_text_encoder_unit #(.MAX_RUN(MAX_RUN)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Encoder state mirrored on the testbench side
    logic [3:0] run_sym = 4'h0;
    logic [7:0] run_len = 8'h00;
    logic       run_open = 1'b0;

    logic [6:0] step_chars[$];
    text_word_t expected_text[$];
    int         errors = 0;
    int         words_rx = 0;
    bit         sender_calm = 1'b0;

    // Directed table: typed rows carry the text read straight off the encoding rules
    logic [3:0] dir_value [DIR_ROWS] = '{4'hF, 4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hA, 4'hA,
                                        4'h9, 4'h9, 4'h9, 4'h5, 4'h6, 4'h6, 4'h7, 4'h3,
                                        4'h3, 4'h3, 4'h4, 4'h4, 4'hB, 4'hC};
    bit dir_last [DIR_ROWS]  = '{1, 0, 0, 0, 1, 1, 0, 1, 0, 0, 1, 0, 0, 0, 1, 0,
                                 0, 0, 0, 1, 0, 1};
    bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                                 1, 1, 1, 1, 0, 0};
    string dir_text [DIR_ROWS] = '{"F", "", "", "", "*40", "F", "", "AA", "", "", "999",
                                   "", "5", "", "667", "", "", "", "333", "44", "", ""};

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("testbench failed");
        $finish;
    end

    function automatic logic [6:0] hex_ascii(input logic [3:0] d);
        if (d < 4'd10) begin
            return ASCII_ZERO + {3'b000, d};
        end
        return ASCII_A + {3'b000, d - 4'd10};
    endfunction

    // Append one character to the current step's text
    function automatic void add_char(input logic [6:0] c);
        step_chars = {step_chars, c};
    endfunction

    task automatic emit_run(input logic [3:0] sym, input logic [7:0] len);
        int k;
        if (len >= 8'd16) begin
            add_char(ASCII_CARET);
            add_char(hex_ascii(len[7:4]));
            add_char(hex_ascii(len[3:0]));
            add_char(hex_ascii(sym));
        end else if (len > 8'd3) begin
            add_char(ASCII_STAR);
            add_char(hex_ascii(len[3:0]));
            add_char(hex_ascii(sym));
        end else begin
            for (k = 0; k < int'(len); k++) begin
                add_char(hex_ascii(sym));
            end
        end
    endtask

    // Characters caused by one accepted symbol, left in step_chars
    task automatic encode_symbol(input logic [3:0] v, input logic last);
        step_chars.delete();
        if (run_open && v == run_sym && run_len < MAX_RUN) begin
            run_len = run_len + 8'd1;
        end else begin
            if (run_open) begin
                emit_run(run_sym, run_len);
            end
            run_sym  = v;
            run_len  = 8'd1;
            run_open = 1'b1;
        end
        if (last) begin
            emit_run(run_sym, run_len);
            run_open = 1'b0;
            run_len  = 8'd0;
            run_sym  = 4'h0;
        end
    endtask

    task automatic queue_text(input logic last);
        text_word_t w;
        int i;
        for (i = 0; i < step_chars.size(); i++) begin
            w.ch        = step_chars[i];
            w.item_done = (i == step_chars.size() - 1);
            w.text_done = last && (i == step_chars.size() - 1);
            expected_text = {expected_text, w};
        end
    endtask

    // Offer one symbol after a random gap and hold it until accepted
    task automatic send_symbol(input logic [3:0] v, input logic last);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, v};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_and_predict(input logic [3:0] v, input logic last);
        send_symbol(v, last);
        encode_symbol(v, last);
        queue_text(last);
    endtask

    task automatic check_word();
        text_word_t w;
        if (expected_text.size() == 0) begin
            $display("%0t: unexpected word, actual tdata=%h tuser=%b tlast=%b",
                     $time, m_tdata, m_tuser, m_tlast);
            errors++;
        end else begin
            w = expected_text.pop_front();
            if (m_tdata !== {1'b0, w.ch}) begin
                $display("%0t: text_char expected %h actual %h", $time, {1'b0, w.ch}, m_tdata);
                errors++;
            end
            if (m_tuser[0] !== w.item_done) begin
                $display("%0t: item_done expected %b actual %b", $time, w.item_done, m_tuser[0]);
                errors++;
            end
            if (m_tlast !== w.text_done) begin
                $display("%0t: text_done expected %b actual %b", $time, w.text_done, m_tlast);
                errors++;
            end
        end
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off to fill the block
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if (words_rx == HOLD_OFF_WORD) begin
                stall = HOLD_OFF_CYCLES;
            end else if ((words_rx % 64) < 16) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_word();
            words_rx++;
        end
    end

    initial begin
        int i, k, len, run_idx, long_a, random_items;
        logic [3:0] sym;
        logic [3:0] prev_sym;
        bit end_last;
        logic last;
        byte ch;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < DIR_ROWS; i++) begin
            send_symbol(dir_value[i], dir_last[i]);
            encode_symbol(dir_value[i], dir_last[i]);
            if (dir_typed[i]) begin
                step_chars.delete();
                for (k = 0; k < dir_text[i].len(); k++) begin
                    ch = dir_text[i][k];
                    add_char(7'(ch));
                end
            end
            queue_text(dir_last[i]);
        end

        // Random runs; one of them goes one symbol past the run limit and ends the text
        long_a = $urandom_range(1, 2);
        random_items = 0;
        prev_sym = 4'h0;
        run_idx = 0;
        while (random_items < RANDOM_ITEMS || run_idx <= long_a) begin
            sender_calm = (run_idx % 8) < 2;
            end_last = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(1, 3);
                5, 6:          len = $urandom_range(4, 15);
                7:             len = $urandom_range(16, 40);
                default:       len = $urandom_range(15, 16);
            endcase
            if (run_idx == long_a) begin
                len = MAX_RUN + 1;
                end_last = 1'b1;
            end
            // Mostly a fresh symbol; now and then a random one, which may repeat and merge into the last run
            if ($urandom_range(0, 7) == 0) begin
                sym = 4'($urandom_range(0, 15));
            end else begin
                sym = prev_sym + 4'($urandom_range(1, 15));
            end
            for (k = 0; k < len; k++) begin
                last = (k == len - 1 && end_last)
                       || (run_idx != long_a && $urandom_range(0, 39) == 0);
                send_and_predict(sym, last);
                random_items++;
            end
            prev_sym = sym;
            run_idx++;
        end
        // Close any open run so the text ends cleanly
        send_and_predict(~prev_sym, 1'b1);
        s_tvalid <= 1'b0;

        while (expected_text.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_text.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hrle_pkg.sv
hdl/hrle_front.sv
hdl/hrle_queue.sv
hdl/hrle_back.sv
hdl/hex_rle_text_encoder_unit.sv
hdl/hrle_checker.sv
sim/testbench.sv
